// ===== rtl/core/lobs_pkg.sv =====
package lobs_pkg;

  localparam int STATES    = 4;
  localparam int INPUTS    = 2;
  localparam int OUTPUTS   = 2;
  localparam int FRAC_BITS = 16;

  localparam int DATA_W = 32;
  localparam int PROD_W = 2 * DATA_W;
  // rounded products carry PROD_W - FRAC_BITS bits; four more hold the row sum
  localparam int ACC_W  = PROD_W - FRAC_BITS + 4;

  localparam int SW = (STATES  > 1) ? $clog2(STATES)  : 1;
  localparam int UW = (INPUTS  > 1) ? $clog2(INPUTS)  : 1;
  localparam int YW = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;

  localparam int TERMS = STATES + INPUTS + OUTPUTS;
  localparam int TW    = $clog2(TERMS);

  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    MAT_A = 2'd0,
    MAT_B = 2'd1,
    MAT_C = 2'd2,
    MAT_L = 2'd3
  } mat_sel_t;

  typedef struct packed {
    logic          valid;
    logic          first;
    logic          last;
    logic          is_x;
    logic [SW-1:0] row;
  } mac_tag_t;

  typedef struct packed {
    logic                     clip;
    logic signed [DATA_W-1:0] val;
  } sat_t;

endpackage

// ===== rtl/core/luenberger_observer_update.sv =====
// Load item: written to the coefficient store on accept; the block stays ready.
// Update item: one shared 32x32 multiply-accumulate runs OUTPUTS*STATES + STATES*TERMS
// products (40 here) plus two pipeline drains; results are then offered one per cycle
// while out_ready is high, and no new item is taken until the last result is taken.
// Reset: coefficient stores and the state estimate clear to zero, the block is idle.
module luenberger_observer_update import lobs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic [1:0]               matrix_select,
  input  logic [2:0]               coef_row,
  input  logic [2:0]               coef_col,
  input  logic signed [DATA_W-1:0] coef_value,
  input  logic signed [DATA_W-1:0] control_in_0,
  input  logic signed [DATA_W-1:0] control_in_1,
  input  logic signed [DATA_W-1:0] measured_0,
  input  logic signed [DATA_W-1:0] measured_1,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [2:0]               state_index,
  output logic signed [DATA_W-1:0] state_value,
  output logic                     saturated,
  output logic                     last
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CX_ISSUE,
    S_CX_DRAIN,
    S_X_ISSUE,
    S_X_DRAIN,
    S_EMIT
  } state_t;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W - DATA_W + 1){1'b1}}, {(DATA_W - 1){1'b0}}};

  function automatic sat_t sat_acc(input logic signed [ACC_W-1:0] v);
    sat_t r;
    if (v > SAT_MAX) begin
      r.clip = 1'b1;
      r.val  = SAT_MAX[DATA_W-1:0];
    end else if (v < SAT_MIN) begin
      r.clip = 1'b1;
      r.val  = SAT_MIN[DATA_W-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = v[DATA_W-1:0];
    end
    return r;
  endfunction

  state_t state;

  logic signed [DATA_W-1:0] a_coef [STATES][STATES];
  logic signed [DATA_W-1:0] b_coef [STATES][INPUTS];
  logic signed [DATA_W-1:0] c_coef [OUTPUTS][STATES];
  logic signed [DATA_W-1:0] l_coef [STATES][OUTPUTS];

  logic signed [DATA_W-1:0] x_est    [STATES];
  logic signed [DATA_W-1:0] x_new    [STATES];
  logic                     clip_est [STATES];
  logic                     clip_new [STATES];
  logic signed [DATA_W-1:0] u_hold   [INPUTS];
  logic signed [DATA_W-1:0] y_hold   [OUTPUTS];
  logic signed [DATA_W-1:0] diff     [OUTPUTS];

  logic [SW-1:0] row;
  logic [TW-1:0] term;
  logic [SW-1:0] emit_idx;

  // ---------------------------------------------------------------- load decode
  logic       in_fire, load_fire, upd_fire;
  logic [3:0] row_ext, col_ext;
  logic       a_wr, b_wr, c_wr, l_wr;

  assign in_ready  = (state == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign load_fire = in_fire && (action == ACT_LOAD);
  assign upd_fire  = in_fire && (action == ACT_UPDATE);
  assign row_ext   = {1'b0, coef_row};
  assign col_ext   = {1'b0, coef_col};

  assign a_wr = load_fire && (matrix_select == MAT_A) &&
                (row_ext < 4'(STATES)) && (col_ext < 4'(STATES));
  assign b_wr = load_fire && (matrix_select == MAT_B) &&
                (row_ext < 4'(STATES)) && (col_ext < 4'(INPUTS));
  assign c_wr = load_fire && (matrix_select == MAT_C) &&
                (row_ext < 4'(OUTPUTS)) && (col_ext < 4'(STATES));
  assign l_wr = load_fire && (matrix_select == MAT_L) &&
                (row_ext < 4'(STATES)) && (col_ext < 4'(OUTPUTS));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STATES; i++) begin
        for (int j = 0; j < STATES; j++) a_coef[i][j] <= '0;
        for (int j = 0; j < INPUTS; j++) b_coef[i][j] <= '0;
        for (int j = 0; j < OUTPUTS; j++) l_coef[i][j] <= '0;
      end
      for (int i = 0; i < OUTPUTS; i++) begin
        for (int j = 0; j < STATES; j++) c_coef[i][j] <= '0;
      end
    end else begin
      if (a_wr) a_coef[coef_row[SW-1:0]][coef_col[SW-1:0]] <= coef_value;
      if (b_wr) b_coef[coef_row[SW-1:0]][coef_col[UW-1:0]] <= coef_value;
      if (c_wr) c_coef[coef_row[YW-1:0]][coef_col[SW-1:0]] <= coef_value;
      if (l_wr) l_coef[coef_row[SW-1:0]][coef_col[YW-1:0]] <= coef_value;
    end
  end

  // ---------------------------------------------------------------- operand select
  logic [TW-1:0]            term_b, term_l;
  logic signed [DATA_W-1:0] sel_a, sel_b;
  mac_tag_t                 issue_tag;
  logic                     row_end, phase_end;

  assign term_b = term - TW'(STATES);
  assign term_l = term - TW'(STATES + INPUTS);

  always_comb begin
    sel_a = c_coef[row[YW-1:0]][term[SW-1:0]];
    sel_b = x_est[term[SW-1:0]];
    issue_tag.valid = 1'b0;
    issue_tag.first = (term == '0);
    issue_tag.is_x  = (state == S_X_ISSUE);
    issue_tag.row   = row;
    issue_tag.last  = 1'b0;
    row_end   = 1'b0;
    phase_end = 1'b0;
    case (state)
      S_CX_ISSUE: begin
        issue_tag.valid = 1'b1;
        row_end   = (term == TW'(STATES - 1));
        phase_end = row_end && (row == SW'(OUTPUTS - 1));
      end
      S_X_ISSUE: begin
        issue_tag.valid = 1'b1;
        row_end   = (term == TW'(TERMS - 1));
        phase_end = row_end && (row == SW'(STATES - 1));
        if (term < TW'(STATES)) begin
          sel_a = a_coef[row][term[SW-1:0]];
          sel_b = x_est[term[SW-1:0]];
        end else if (term < TW'(STATES + INPUTS)) begin
          sel_a = b_coef[row][term_b[UW-1:0]];
          sel_b = u_hold[term_b[UW-1:0]];
        end else begin
          sel_a = l_coef[row][term_l[YW-1:0]];
          sel_b = diff[term_l[YW-1:0]];
        end
      end
      default: begin
      end
    endcase
    issue_tag.last = row_end;
  end

  // ---------------------------------------------------------------- shared MAC pipeline
  mac_tag_t                 t1, t2, t3;
  logic signed [DATA_W-1:0] op_a, op_b;
  logic signed [PROD_W-1:0] prod, prod_rnd, prod_shr;
  logic signed [ACC_W-1:0]  rnd_term, acc;
  logic                     pipe_empty;

  assign prod_rnd   = prod + ROUND_HALF;
  assign prod_shr   = prod_rnd >>> FRAC_BITS;
  assign rnd_term   = prod_shr[ACC_W-1:0];
  assign pipe_empty = !t1.valid && !t2.valid && !t3.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
    end else begin
      t1 <= issue_tag;
      t2 <= t1;
      t3 <= t2;
    end
    op_a <= sel_a;
    op_b <= sel_b;
    prod <= op_a * op_b;
    if (t2.valid) acc <= (t2.first ? '0 : acc) + rnd_term;
  end

  // ---------------------------------------------------------------- row finish
  sat_t                     fin, dsat;
  logic signed [DATA_W:0]   diff_wide;

  always_comb begin
    fin       = sat_acc(acc);
    diff_wide = {y_hold[t3.row[YW-1:0]][DATA_W-1], y_hold[t3.row[YW-1:0]]} -
                {fin.val[DATA_W-1], fin.val};
    dsat      = sat_acc(ACC_W'(diff_wide));
  end

  always_ff @(posedge clk) begin
    if (t3.valid && t3.last) begin
      if (t3.is_x) begin
        x_new[t3.row]    <= fin.val;
        clip_new[t3.row] <= fin.clip;
      end else begin
        diff[t3.row[YW-1:0]] <= dsat.val;
      end
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      row       <= '0;
      term      <= '0;
      emit_idx  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < STATES; i++) x_est[i] <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          row  <= '0;
          term <= '0;
          if (upd_fire) begin
            u_hold[0] <= control_in_0;
            if (INPUTS > 1) u_hold[INPUTS-1] <= control_in_1;
            y_hold[0] <= measured_0;
            if (OUTPUTS > 1) y_hold[OUTPUTS-1] <= measured_1;
            state <= S_CX_ISSUE;
          end
        end
        S_CX_ISSUE, S_X_ISSUE: begin
          if (row_end) begin
            term <= '0;
            if (phase_end) begin
              row   <= '0;
              state <= (state == S_CX_ISSUE) ? S_CX_DRAIN : S_X_DRAIN;
            end else begin
              row <= row + 1'b1;
            end
          end else begin
            term <= term + 1'b1;
          end
        end
        S_CX_DRAIN: begin
          // innovations must be final before any L term is issued
          if (pipe_empty) state <= S_X_ISSUE;
        end
        S_X_DRAIN: begin
          if (pipe_empty) begin
            for (int i = 0; i < STATES; i++) begin
              x_est[i]    <= x_new[i];
              clip_est[i] <= clip_new[i];
            end
            emit_idx    <= '0;
            out_valid   <= 1'b1;
            state_index <= '0;
            state_value <= x_new[0];
            saturated   <= clip_new[0];
            last        <= (STATES == 1);
            state       <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_ready) begin
            if (emit_idx == SW'(STATES - 1)) begin
              out_valid <= 1'b0;
              state     <= S_IDLE;
            end else begin
              emit_idx    <= emit_idx + 1'b1;
              state_index <= 3'(emit_idx + 1'b1);
              state_value <= x_est[emit_idx + 1'b1];
              saturated   <= clip_est[emit_idx + 1'b1];
              last        <= ((emit_idx + 1'b1) == SW'(STATES - 1));
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- assertions
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input accepted while results pending");

  a_mac_in_phase: assert property (@(posedge clk) disable iff (rst)
    t3.valid |-> (state == S_CX_ISSUE || state == S_CX_DRAIN ||
                  state == S_X_ISSUE || state == S_X_DRAIN))
    else $error("MAC active outside compute phases");

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last) |=> in_ready)
    else $error("block not ready after last element");

  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=>
      (out_valid && state_index == $past(state_index) + 3'd1))
    else $error("state index did not advance");

  a_load_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == ACT_LOAD) |=> in_ready)
    else $error("coefficient load stalled the block");

endmodule
